@@ rtl/hng_pkg.sv @@
package hng_pkg;

  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int MAX_ROWS = 4096;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [1:0] REG_NUM_COLS     = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS     = 2'd1;
  localparam logic [1:0] REG_CELL_SPACING = 2'd2;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic [9:0]         col;
    logic [11:0]        row;
    logic               fend;
    logic               last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_RDA,
    F_RDB,
    F_WR,
    F_EMIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_LEN,
    B_DIVI,
    B_DIV,
    B_SQRT,
    B_STORE,
    B_DONE
  } back_state_t;

endpackage

@@ rtl/hng_front.sv @@
module hng_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic [10:0]        cols,
  input  logic [12:0]        rows,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        height_sample,
  input  logic               q_full,
  output logic               q_push,
  output hng_pkg::job_t      q_job
);
  import hng_pkg::*;

  front_state_t state, state_next;

  logic [15:0]      rd_data;
  logic [COL_W-1:0] rd_addr;
  logic             mem_we;

  logic [COL_W-1:0] col_count;
  logic [11:0]      row_count;
  logic [15:0]      prev_sample;

  logic [COL_W-1:0] x;
  logic [11:0]      y;
  logic [15:0]      h;
  logic [15:0]      p;
  logic [15:0]      a_val;
  logic [15:0]      b_val;
  logic             has0, has1, has2, last_col;
  logic [1:0]       k;

  logic             lc, lr, accept, cur_has, cur_last;

  logic [15:0] mem_q [MAX_COLS];

  assign lc     = (11'(col_count) + 11'd1) >= cols;
  assign lr     = (13'(row_count) + 13'd1) >= rows;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[x] <= h;
    end
    rd_data <= mem_q[rd_addr];
  end

  always_comb begin
    rd_addr = x;
    if (state == F_RDB && !last_col) begin
      rd_addr = x + COL_W'(1);
    end
  end

  always_comb begin
    unique case (k)
      2'd0:    begin cur_has = has0; cur_last = !has1 && !has2; end
      2'd1:    begin cur_has = has1; cur_last = !has2; end
      default: begin cur_has = has2; cur_last = 1'b1; end
    endcase
  end

  always_comb begin
    q_job = '0;
    unique case (k)
      2'd0: begin
        q_job.a   = a_val;
        q_job.b   = b_val;
        q_job.c   = h;
        q_job.col = x;
        q_job.row = y - 12'd1;
      end
      2'd1: begin
        q_job.a   = p;
        q_job.b   = h;
        q_job.c   = p;
        q_job.col = x - COL_W'(1);
        q_job.row = y;
      end
      default: begin
        q_job.a    = h;
        q_job.b    = h;
        q_job.c    = h;
        q_job.col  = x;
        q_job.row  = y;
        q_job.fend = 1'b1;
      end
    endcase
    q_job.last = cur_last;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = F_RDA;
        end
      end
      F_RDA: state_next = F_RDB;
      F_RDB: state_next = F_WR;
      F_WR: begin
        mem_we     = 1'b1;
        state_next = F_EMIT;
      end
      F_EMIT: begin
        q_push = cur_has && !q_full;
        if ((q_push || !cur_has) && k == 2'd2) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      prev_sample <= '0;
    end else if (restart) begin
      col_count   <= '0;
      row_count   <= '0;
      prev_sample <= '0;
    end else if (accept) begin
      prev_sample <= height_sample;
      if (lc) begin
        col_count <= '0;
        row_count <= lr ? 12'd0 : row_count + 12'd1;
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x        <= col_count;
      y        <= row_count;
      h        <= height_sample;
      p        <= prev_sample;
      last_col <= lc;
      has0     <= row_count != 12'd0;
      has1     <= lr && col_count != '0;
      has2     <= lr && lc;
    end
    if (state == F_RDB) begin
      a_val <= rd_data;
    end
    if (state == F_WR) begin
      b_val <= last_col ? a_val : rd_data;
      k     <= 2'd0;
    end
    if (state == F_EMIT && (q_push || !cur_has)) begin
      k <= k + 2'd1;
    end
  end

endmodule

@@ rtl/hng_queue.sv @@
module hng_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hng_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output hng_pkg::job_t rdata,
  output logic          empty
);
  import hng_pkg::*;

  job_t               slots [QDEPTH];
  logic [QPTR_W:0]    wptr;
  logic [QPTR_W:0]    rptr;

  assign empty = wptr == rptr;
  assign full  = (wptr[QPTR_W-1:0] == rptr[QPTR_W-1:0]) && (wptr[QPTR_W] != rptr[QPTR_W]);
  assign rdata = slots[rptr[QPTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr[QPTR_W-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + (QPTR_W+1)'(1);
      end
      if (pop && !empty) begin
        rptr <= rptr + (QPTR_W+1)'(1);
      end
    end
  end

endmodule

@@ rtl/hng_back.sv @@
module hng_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    spacing,
  input  logic          job_valid,
  input  hng_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   normal_x,
  output logic [14:0]   normal_y,
  output logic [15:0]   normal_z,
  output logic [9:0]    point_col,
  output logic [11:0]   point_row,
  output logic          frame_end,
  output logic          run_last
);
  import hng_pkg::*;

  back_state_t state, state_next;

  logic [15:0] adx, adz;
  logic        neg_x, neg_z;
  logic [31:0] sqx, sqy, sqz;
  logic [33:0] len2;
  logic [1:0]  comp;
  logic [4:0]  cnt;
  logic [33:0] rem;
  logic [30:0] quo;
  logic [17:0] sq_rem;
  logic [15:0] root;
  logic [14:0] qx, qy, qz;
  logic [9:0]  j_col;
  logic [11:0] j_row;
  logic        j_fend, j_last;

  logic signed [16:0] dx, dz;
  logic [15:0] s_val, m_op;
  logic [31:0] prod, v2;
  logic [34:0] div_t;
  logic        div_ge;
  logic [31:0] dq;
  logic [3:0]  sq_i;
  logic [1:0]  pair;
  logic [19:0] r2, trial;
  logic [14:0] qnew;
  logic [16:0] root_inc;
  logic        load_out;

  assign dx    = 17'(job.b) - 17'(job.a);
  assign dz    = 17'(job.c) - 17'(job.a);
  assign s_val = {spacing, 8'd0};

  always_comb begin
    unique case (comp)
      2'd0:    begin m_op = adx;   v2 = sqx; end
      2'd1:    begin m_op = s_val; v2 = sqy; end
      default: begin m_op = adz;   v2 = sqz; end
    endcase
  end

  assign prod   = m_op * m_op;
  assign div_t  = {rem, (cnt == 5'd0) ? v2[0] : 1'b0};
  assign div_ge = div_t >= 35'(len2);

  assign dq    = {1'b0, quo};
  assign sq_i  = 4'd15 - cnt[3:0];
  assign pair  = dq[{sq_i, 1'b0} +: 2];
  assign r2    = {sq_rem, pair};
  assign trial = {2'b00, root, 2'b01};

  assign root_inc = 17'(root) + 17'd1;
  assign qnew     = root_inc[15:1];

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = B_SQ;
        end
      end
      B_SQ:    if (comp == 2'd2) state_next = B_LEN;
      B_LEN:   state_next = B_DIVI;
      B_DIVI:  state_next = B_DIV;
      B_DIV:   if (cnt == 5'd30) state_next = B_SQRT;
      B_SQRT:  if (cnt == 5'd15) state_next = B_STORE;
      B_STORE: state_next = (comp == 2'd2) ? B_DONE : B_DIVI;
      B_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        adx    <= dx[16] ? 16'(-dx) : dx[15:0];
        adz    <= dz[16] ? 16'(-dz) : dz[15:0];
        neg_x  <= !dx[16] && dx != 17'sd0;
        neg_z  <= !dz[16] && dz != 17'sd0;
        j_col  <= job.col;
        j_row  <= job.row;
        j_fend <= job.fend;
        j_last <= job.last;
        comp   <= 2'd0;
      end
      B_SQ: begin
        unique case (comp)
          2'd0:    sqx <= prod;
          2'd1:    sqy <= prod;
          default: sqz <= prod;
        endcase
        comp <= comp + 2'd1;
      end
      B_LEN: begin
        len2 <= 34'(sqx) + 34'(sqy) + 34'(sqz);
        comp <= 2'd0;
      end
      B_DIVI: begin
        rem <= 34'(v2[31:1]);
        quo <= '0;
        cnt <= 5'd0;
      end
      B_DIV: begin
        rem <= div_ge ? 34'(div_t - 35'(len2)) : div_t[33:0];
        quo <= {quo[29:0], div_ge};
        cnt <= (cnt == 5'd30) ? 5'd0 : cnt + 5'd1;
        if (cnt == 5'd30) begin
          sq_rem <= '0;
          root   <= '0;
        end
      end
      B_SQRT: begin
        if (r2 >= trial) begin
          sq_rem <= 18'(r2 - trial);
          root   <= {root[14:0], 1'b1};
        end else begin
          sq_rem <= r2[17:0];
          root   <= {root[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      B_STORE: begin
        unique case (comp)
          2'd0:    qx <= qnew;
          2'd1:    qy <= qnew;
          default: qz <= qnew;
        endcase
        comp <= comp + 2'd1;
      end
      B_DONE: begin
        if (load_out) begin
          normal_x  <= neg_x ? 16'd0 - {1'b0, qx} : {1'b0, qx};
          normal_y  <= qy;
          normal_z  <= neg_z ? 16'd0 - {1'b0, qz} : {1'b0, qz};
          point_col <= j_col;
          point_row <= j_row;
          frame_end <= j_fend;
          run_last  <= j_last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/heightmap_normal_generator.sv @@
// Heightmap normal generator.
// Input: height_sample (signed Q8.8) in raster order, transfer on
// in_valid & in_ready. Output: one unit normal (Q1.14) per grid point with
// its column/row, frame_end on the final point and run_last on the last
// result caused by an input, transfer on out_valid & out_ready.
// Normals of row r come out while row r+1 streams in; on the last row a
// sample may cause up to three normals.
// Configuration: APB registers num_cols (0x0), num_rows (0x4),
// cell_spacing (0x8); any write to these restarts the map at point (0,0).
// Flow: the front end takes a new sample only after the last one has passed
// transfer, two line buffer reads, write and three job slots, and it waits
// while the queue is full. The back end works on one normal at a time:
// three squares, then per component a 31-step restoring divide and a
// 16-step square root on one shared unit. A 4-entry queue sits between
// the two.
// Reset: control cleared, registers to 1024 cols, 1024 rows, spacing 1.
// The line buffer is not cleared. When the receiver stalls, the output
// register holds and the back end, then the queue, then input back up.
module heightmap_normal_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] height_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] normal_x,
  output logic [14:0] normal_y,
  output logic [15:0] normal_z,
  output logic [9:0]  point_col,
  output logic [11:0] point_row,
  output logic        frame_end,
  output logic        run_last
);
  import hng_pkg::*;

  logic [10:0] num_cols;
  logic [12:0] num_rows;
  logic [7:0]  cell_spacing;
  logic [10:0] cols;
  logic [12:0] rows;
  logic [7:0]  spacing;
  logic        cfg_wr, restart;
  logic [1:0]  idx;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wjob, q_rjob;

  assign pready  = 1'b1;
  assign idx     = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (idx == REG_NUM_COLS || idx == REG_NUM_ROWS ||
                              idx == REG_CELL_SPACING);

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_NUM_COLS:     prdata = 32'(num_cols);
      REG_NUM_ROWS:     prdata = 32'(num_rows);
      REG_CELL_SPACING: prdata = 32'(cell_spacing);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols     <= 11'd1024;
      num_rows     <= 13'd1024;
      cell_spacing <= 8'd1;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_NUM_COLS:     num_cols     <= pwdata[10:0];
        REG_NUM_ROWS:     num_rows     <= pwdata[12:0];
        REG_CELL_SPACING: cell_spacing <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols = num_cols;
    if (num_cols == '0) cols = 11'd1;
    else if (num_cols > 11'(MAX_COLS)) cols = 11'(MAX_COLS);
    rows = num_rows;
    if (num_rows == '0) rows = 13'd1;
    else if (num_rows > 13'(MAX_ROWS)) rows = 13'(MAX_ROWS);
    spacing = (cell_spacing == '0) ? 8'd1 : cell_spacing;
  end

  hng_front u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .cols          (cols),
    .rows          (rows),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .height_sample (height_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_wjob)
  );

  hng_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wjob),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rjob),
    .empty (q_empty)
  );

  hng_back u_back (
    .clk       (clk),
    .rst       (rst),
    .spacing   (spacing),
    .job_valid (!q_empty),
    .job       (q_rjob),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .point_col (point_col),
    .point_row (point_row),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

endmodule

@@ verif/hng_normal_checker.sv @@
module hng_normal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] height_sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] normal_x,
  input  logic [14:0] normal_y,
  input  logic [15:0] normal_z,
  input  logic [9:0]  point_col,
  input  logic [11:0] point_row,
  input  logic        frame_end,
  input  logic        run_last,
  output int          errors,
  output int          pending,
  output int          samples_seen,
  output int          normals_seen,
  output int          cfg_writes
);
  import hng_pkg::*;

  typedef struct packed {
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic [9:0]  col;
    logic [11:0] row;
    logic        fend;
    logic        last;
  } normal_t;

  normal_t     normal_q[$];
  logic [15:0] line_buf[MAX_COLS];
  logic [15:0] prev_h;
  int unsigned cur_col, cur_row;
  logic [10:0] cols_reg;
  logic [12:0] rows_reg;
  logic [7:0]  spacing_reg;

  initial begin
    errors = 0;
    pending = 0;
    samples_seen = 0;
    normals_seen = 0;
    cfg_writes = 0;
    for (int i = 0; i < MAX_COLS; i++) line_buf[i] = '0;
  end

  // Q1.14 magnitude of v over len, rounded half up
  function automatic logic [14:0] unit_mag(longint unsigned v2, longint unsigned len2);
    int unsigned lo, hi, mid;
    longint unsigned t;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * len2 <= (v2 << 30)) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  function automatic normal_t make_normal(int a, int b, int c, int unsigned col,
                                          int unsigned row, bit fend);
    longint dx, dz;
    longint unsigned adx, adz, s, len2;
    logic [15:0] qx, qz;
    normal_t r;
    dx = longint'(b) - longint'(a);
    dz = longint'(c) - longint'(a);
    adx = (dx < 0) ? -dx : dx;
    adz = (dz < 0) ? -dz : dz;
    s = ((spacing_reg == 0) ? 1 : spacing_reg) * 256;
    len2 = adx * adx + s * s + adz * adz;
    qx = {1'b0, unit_mag(adx * adx, len2)};
    qz = {1'b0, unit_mag(adz * adz, len2)};
    r.nx = (dx > 0) ? -qx : qx;
    r.ny = unit_mag(s * s, len2);
    r.nz = (dz > 0) ? -qz : qz;
    r.col = col[9:0];
    r.row = row[11:0];
    r.fend = fend;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic take_sample(logic [15:0] raw);
    int unsigned cols, rows, x, y;
    int h, a, b;
    bit last_row, last_col;
    normal_t res[$];
    cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    x = cur_col;
    y = cur_row;
    h = int'($signed(raw));
    last_row = (y + 1 >= rows);
    last_col = (x + 1 >= cols);
    if (y >= 1) begin
      a = int'($signed(line_buf[x]));
      b = last_col ? a : int'($signed(line_buf[x + 1]));
      res.push_back(make_normal(a, b, h, x, y - 1, 1'b0));
    end
    if (last_row) begin
      if (x >= 1) begin
        a = int'($signed(prev_h));
        res.push_back(make_normal(a, h, a, x - 1, y, 1'b0));
      end
      if (last_col) res.push_back(make_normal(h, h, h, x, y, 1'b1));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) normal_q.push_back(res[i]);
    line_buf[x] = raw;
    prev_h = raw;
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : y + 1;
    end else begin
      cur_col = x + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      normal_q.delete();
      prev_h = '0;
      cur_col = 0;
      cur_row = 0;
      cols_reg = 11'd1024;
      rows_reg = 13'd1024;
      spacing_reg = 8'd1;
    end else begin
      if (psel && penable && pwrite && pready && paddr[3:2] <= REG_CELL_SPACING) begin
        case (paddr[3:2])
          REG_NUM_COLS: cols_reg = pwdata[10:0];
          REG_NUM_ROWS: rows_reg = pwdata[12:0];
          default: spacing_reg = pwdata[7:0];
        endcase
        cur_col = 0;
        cur_row = 0;
        prev_h = '0;
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        take_sample(height_sample);
        samples_seen++;
      end
      if (out_valid && out_ready) begin
        normals_seen++;
        if (normal_q.size() == 0) begin
          $error("unexpected normal at col %0d row %0d", point_col, point_row);
          errors++;
        end else begin
          normal_t e;
          e = normal_q.pop_front();
          if (normal_x !== e.nx) begin
            $error("normal_x expected %0d got %0d", $signed(e.nx), $signed(normal_x));
            errors++;
          end
          if (normal_y !== e.ny) begin
            $error("normal_y expected %0d got %0d", e.ny, normal_y);
            errors++;
          end
          if (normal_z !== e.nz) begin
            $error("normal_z expected %0d got %0d", $signed(e.nz), $signed(normal_z));
            errors++;
          end
          if (point_col !== e.col) begin
            $error("point_col expected %0d got %0d", e.col, point_col);
            errors++;
          end
          if (point_row !== e.row) begin
            $error("point_row expected %0d got %0d", e.row, point_row);
            errors++;
          end
          if (frame_end !== e.fend) begin
            $error("frame_end expected %0d got %0d", e.fend, frame_end);
            errors++;
          end
          if (run_last !== e.last) begin
            $error("run_last expected %0d got %0d", e.last, run_last);
            errors++;
          end
        end
      end
    end
    pending = normal_q.size();
  end

endmodule

@@ verif/heightmap_normal_generator_tb.sv @@
module heightmap_normal_generator_tb;
  import hng_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 600;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [15:0] height_sample;
  logic        out_valid, out_ready;
  logic [15:0] normal_x, normal_z;
  logic [14:0] normal_y;
  logic [9:0]  point_col;
  logic [11:0] point_row;
  logic        frame_end, run_last;

  int errors, pending, samples_seen, normals_seen, cfg_writes;
  int idle_pct, stall_pct, cycles;
  bit hold_go;

  heightmap_normal_generator DUT (.*);

  hng_normal_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("heightmap_normal_generator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        out_ready <= 0;
        repeat (800) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic configure(int cols, int rows, int sp);
    reg_write({REG_NUM_COLS, 2'b00}, cols);
    reg_write({REG_NUM_ROWS, 2'b00}, rows);
    reg_write({REG_CELL_SPACING, 2'b00}, sp);
  endtask

  // entered and left at a falling edge
  task automatic send_sample(logic [15:0] h);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 0;
      height_sample <= 16'($urandom);
      @(negedge clk);
    end
    in_valid <= 1;
    height_sample <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_height(logic [15:0] base);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(base + $urandom_range(0, 1023) - 512);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int cols, rows, sp, ecols, erows, n, sent;
    logic [15:0] base;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid = 0;
    height_sample = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 0;
    cycles = 0;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // defaults: first row yields nothing
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    drain();
    // single point maps, zero spacing and zero sizes
    configure(1, 1, 0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain();
    configure(0, 0, 255);
    send_sample(16'hFFFF);
    drain();
    // 2x2 with extreme slopes: last sample gives three normals
    configure(2, 2, 1);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain();
    configure(3, 2, 255);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'h7FFF : 16'h8000);
    drain();
    // oversized registers saturate; upper bits ignored; write past the map ignored
    configure(32'hFFFF_F7FF, 32'hFFFF_FFFF, 32'hFFFF_FF00);
    reg_write(4'hC, 32'd3);
    for (int i = 0; i < 6; i++) send_sample(16'($urandom));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 59 : ((ph == 3) ? 28 : 0);
      stall_pct = (ph == 2) ? 59 : ((ph == 3) ? 28 : 0);
      if (ph == 0) hold_go = 1;
      sent = 0;
      while (sent < 80) begin
        cols = $urandom_range(1, 6);
        rows = $urandom_range(1, 5);
        sp = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 255 : 1)
                                           : $urandom_range(0, 255);
        if ($urandom_range(0, 15) == 0) cols = 0;
        if ($urandom_range(0, 15) == 0) rows = 0;
        ecols = (cols == 0) ? 1 : cols;
        erows = (rows == 0) ? 1 : rows;
        n = ecols * erows * $urandom_range(1, 2);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        if ($urandom_range(0, 19) == 0) begin
          cols = 2047;
          n = $urandom_range(4, 12);
        end
        if (n > 40) n = 40;
        configure(cols, rows, sp);
        base = 16'($urandom);
        for (int i = 0; i < n; i++) send_sample(pick_height(base));
        sent += n;
        drain();
      end
    end

    $display("Covered %0d samples, %0d normals and %0d register writes", samples_seen,
             normals_seen, cfg_writes);
    $display("across small maps, saturated sizes, sender gaps, stalls and a long hold.");
    if (errors == 0) begin
      $display("heightmap_normal_generator_tb: PASS");
    end else begin
      $display("heightmap_normal_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
